// ===== hdl/sct_pkg.sv =====
// Shared types, mode codes and configuration defaults for the solar charge tracker.
package sct_pkg;

  // Charger modes as reported on the result channel.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BULK  = 2'd2;
  localparam logic [1:0] MODE_FLOAT = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 4;
  localparam logic [CFG_IW-1:0] REG_MIN_BATTERY_MV   = 4'd0;
  localparam logic [CFG_IW-1:0] REG_HIGH_BATTERY_MV  = 4'd1;
  localparam logic [CFG_IW-1:0] REG_MAX_BATTERY_MV   = 4'd2;
  localparam logic [CFG_IW-1:0] REG_MIN_SOURCE_POWER = 4'd3;
  localparam logic [CFG_IW-1:0] REG_LOW_SOURCE_POWER = 4'd4;
  localparam logic [CFG_IW-1:0] REG_DUTY_STEP        = 4'd5;
  localparam logic [CFG_IW-1:0] REG_START_DUTY       = 4'd6;
  localparam logic [CFG_IW-1:0] REG_MAX_DUTY         = 4'd7;

  // Configuration reset values.
  localparam logic [15:0] RST_MIN_BATTERY_MV   = 16'd10500;
  localparam logic [15:0] RST_HIGH_BATTERY_MV  = 16'd13500;
  localparam logic [15:0] RST_MAX_BATTERY_MV   = 16'd14400;
  localparam logic [31:0] RST_MIN_SOURCE_POWER = 32'd500000;
  localparam logic [31:0] RST_LOW_SOURCE_POWER = 32'd2000000;
  localparam logic [9:0]  RST_DUTY_STEP        = 10'd4;
  localparam logic [9:0]  RST_START_DUTY       = 10'd512;
  localparam logic [9:0]  RST_MAX_DUTY         = 10'd1000;

  // Measurement queue between front and back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = 1;
  localparam int unsigned FIFO_CW    = 2;

  typedef struct packed {
    logic [15:0] min_battery_mv;
    logic [15:0] high_battery_mv;
    logic [15:0] max_battery_mv;
    logic [31:0] min_source_power;
    logic [31:0] low_source_power;
    logic [9:0]  duty_step;
    logic [9:0]  start_duty;
    logic [9:0]  max_duty;
  } sct_cfg_t;

  // One smoothed measurement, as handed from front to back.
  typedef struct packed {
    logic [15:0] battery;
    logic [15:0] source_v;
    logic [31:0] power;
  } sct_meas_t;

endpackage

// ===== hdl/sct_front.sv =====
// Front end: accepts samples, runs the moving averages and forms source power.
module sct_front import sct_pkg::*; #(
  parameter int unsigned SMOOTH_SHIFT = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          battery_mv_i,
  input  logic [15:0]          source_mv_i,
  input  logic [15:0]          source_ma_i,
  input  logic [FIFO_CW-1:0]   fifo_count_i,
  output logic                 push_o,
  output sct_meas_t            push_data_o
);

  logic [15:0] batt_avg_q, batt_avg_d;
  logic [15:0] srcv_avg_q, srcv_avg_d;
  logic [15:0] srci_avg_q, srci_avg_d;
  logic        pend_q;
  logic        accept;

  function automatic logic [15:0] smooth(input logic [15:0] avg, input logic [15:0] sample);
    logic [15:0] diff;
    begin
      if (sample >= avg) begin
        diff = sample - avg;
        smooth = avg + (diff >> SMOOTH_SHIFT);
      end else begin
        diff = avg - sample;
        smooth = avg - (diff >> SMOOTH_SHIFT);
      end
    end
  endfunction

  // The pending measurement still needs a queue slot of its own.
  assign in_stall_o = ((FIFO_CW+1)'(fifo_count_i) + (FIFO_CW+1)'(pend_q))
                      >= (FIFO_CW+1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign batt_avg_d = smooth(batt_avg_q, battery_mv_i);
  assign srcv_avg_d = smooth(srcv_avg_q, source_mv_i);
  assign srci_avg_d = smooth(srci_avg_q, source_ma_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batt_avg_q <= '0;
      srcv_avg_q <= '0;
      srci_avg_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= accept;
      if (accept) begin
        batt_avg_q <= batt_avg_d;
        srcv_avg_q <= srcv_avg_d;
        srci_avg_q <= srci_avg_d;
      end
    end
  end

  assign push_o               = pend_q;
  assign push_data_o.battery  = batt_avg_q;
  assign push_data_o.source_v = srcv_avg_q;
  assign push_data_o.power    = srcv_avg_q * srci_avg_q;

endmodule

// ===== hdl/sct_fifo.sv =====
// Two-entry measurement queue between the front end and the charge controller.
module sct_fifo import sct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sct_meas_t          push_data_i,
  input  logic               pop_i,
  output sct_meas_t          pop_data_o,
  output logic               empty_o,
  output logic [FIFO_CW-1:0] count_o
);

  sct_meas_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;

endmodule

// ===== hdl/sct_div.sv =====
// Restoring divider, one quotient bit per cycle, for the duty ratio seed.
module sct_div #(
  parameter int unsigned QW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [16+QW-1:0] dividend_i,
  input  logic [15:0]      divisor_i,
  output logic             done_o,
  output logic [QW-1:0]    quot_o
);

  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [15:0]     rem_q, rem_d;
  logic [QW-1:0]   quo_q;
  logic [15:0]     div_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic [16:0]     trial;
  logic            ge;

  // The caller guarantees dividend < divisor * 2**QW, so the upper part
  // starts below the divisor and the quotient fits in QW bits.
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? 16'(trial - {1'b0, div_q}) : trial[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[16+QW-1:QW];
      quo_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/sct_back.sv =====
// Charge controller: mode machine, duty tracking and the result register.
module sct_back import sct_pkg::*; #(
  parameter int unsigned DUTY_FULL  = 1023,
  parameter int unsigned FLOAT_DUTY = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sct_cfg_t    cfg_i,
  input  logic        fifo_empty_i,
  input  sct_meas_t   fifo_data_i,
  output logic        fifo_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  duty_o,
  output logic        drive_enable_o,
  output logic [1:0]  mode_o,
  output logic [31:0] source_power_o
);

  localparam int unsigned DW = $clog2(DUTY_FULL + 1);
  localparam int unsigned NW = 16 + DW;
  localparam int unsigned CW = 17;
  localparam logic [CW-1:0] FULL_X = CW'(DUTY_FULL);
  localparam logic [DW-1:0] FULL_D = DW'(DUTY_FULL);
  localparam logic [DW-1:0] FLOAT_D =
    DW'((FLOAT_DUTY > DUTY_FULL) ? DUTY_FULL : FLOAT_DUTY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]    state_q;
  logic [1:0]    mode_q, mode_n;
  logic [DW-1:0] duty_q, duty_n;
  logic          sd_q, sd_n;
  logic [31:0]   last_q, last_n;
  logic          need_div;
  logic          flip;
  logic [15:0]   bv_q, sv_q;
  logic [31:0]   pw_q;
  logic [NW-1:0] prod_q;
  logic          div_start, div_done;
  logic [DW-1:0] div_quot;
  logic          out_valid_q;
  logic [9:0]    out_duty_q;
  logic [1:0]    out_mode_q;
  logic [31:0]   out_power_q;
  logic [CW-1:0] duty_x, step_x;

  function automatic logic [DW-1:0] cap(input logic [CW-1:0] d);
    cap = (d > FULL_X) ? FULL_D : DW'(d);
  endfunction

  assign duty_x = CW'(duty_q);
  assign step_x = CW'(cfg_i.duty_step);

  always_comb begin
    mode_n   = mode_q;
    duty_n   = duty_q;
    sd_n     = sd_q;
    last_n   = last_q;
    need_div = 1'b0;
    flip     = 1'b0;
    case (mode_q)
      MODE_OFF: begin
        if (bv_q > cfg_i.high_battery_mv && bv_q < cfg_i.max_battery_mv && sv_q > bv_q) begin
          duty_n = FLOAT_D;
          mode_n = MODE_FLOAT;
        end else if (bv_q > cfg_i.min_battery_mv && bv_q < cfg_i.max_battery_mv
                     && sv_q > bv_q) begin
          duty_n = cap(CW'(cfg_i.start_duty));
          mode_n = MODE_ON;
        end
      end
      MODE_ON: begin
        if (pw_q < cfg_i.min_source_power) begin
          mode_n = MODE_OFF;
        end else if (bv_q > cfg_i.max_battery_mv) begin
          duty_n = FLOAT_D;
          mode_n = MODE_FLOAT;
        end else if (pw_q < cfg_i.low_source_power) begin
          duty_n = cap(CW'(cfg_i.max_duty));
        end else if (bv_q >= sv_q) begin
          // Ratio of one or more, zero source voltage included, saturates.
          duty_n = FULL_D;
          mode_n = MODE_BULK;
          sd_n   = 1'b0;
        end else begin
          need_div = 1'b1;
        end
      end
      MODE_BULK: begin
        if (pw_q < cfg_i.min_source_power) begin
          mode_n = MODE_OFF;
        end else if (bv_q > cfg_i.max_battery_mv) begin
          duty_n = FLOAT_D;
          mode_n = MODE_FLOAT;
        end else if (pw_q < cfg_i.low_source_power) begin
          duty_n = cap(CW'(cfg_i.start_duty));
          mode_n = MODE_ON;
        end else begin
          flip   = (last_q >= pw_q);
          sd_n   = sd_q ^ flip;
          last_n = pw_q;
          if (sd_n) begin
            duty_n = (duty_x > step_x) ? DW'(duty_x - step_x) : '0;
          end else begin
            duty_n = cap(duty_x + step_x);
          end
        end
      end
      default: begin
        if (pw_q < cfg_i.min_source_power) begin
          mode_n = MODE_OFF;
        end else if (bv_q > cfg_i.max_battery_mv) begin
          if (duty_q != '0) begin
            duty_n = duty_q - 1'b1;
          end
        end else if (bv_q < cfg_i.max_battery_mv) begin
          if ((duty_x + CW'(1)) >= FULL_X) begin
            mode_n = MODE_BULK;
            sd_n   = 1'b0;
          end else begin
            duty_n = DW'(duty_x + CW'(1));
          end
        end
      end
    endcase
  end

  assign fifo_pop_o = (state_q == S_IDLE) && !fifo_empty_i && !out_valid_q;
  assign div_start  = (state_q == S_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_ON;
      duty_q      <= '0;
      sd_q        <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (fifo_pop_o) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (need_div) begin
            state_q <= S_MUL;
          end else begin
            mode_q      <= mode_n;
            duty_q      <= duty_n;
            sd_q        <= sd_n;
            last_q      <= last_n;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mode_q      <= MODE_BULK;
            duty_q      <= div_quot;
            sd_q        <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      bv_q <= fifo_data_i.battery;
      sv_q <= fifo_data_i.source_v;
      pw_q <= fifo_data_i.power;
    end
    if (state_q == S_EVAL) begin
      prod_q      <= NW'(bv_q) * NW'(DUTY_FULL);
      out_duty_q  <= 10'(duty_n);
      out_mode_q  <= mode_n;
      out_power_q <= pw_q;
    end
    if (state_q == S_DIV && div_done) begin
      out_duty_q <= 10'(div_quot);
      out_mode_q <= MODE_BULK;
    end
  end

  sct_div #(
    .QW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (sv_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign out_valid_o    = out_valid_q;
  assign duty_o         = out_duty_q;
  assign mode_o         = out_mode_q;
  assign drive_enable_o = (out_mode_q != MODE_OFF);
  assign source_power_o = out_power_q;

endmodule

// ===== hdl/solar_charge_tracker.sv =====
// Top level of the perturb-and-observe solar charge tracker.
//
// Each input item is one sensor tick (battery voltage, source voltage and
// source current). Every accepted item yields exactly one result item with
// the PWM duty, the output-stage enable, the charger mode and the smoothed
// source power. Items are accepted when in_valid_i is high and in_stall_o
// is low; results leave when out_valid_o is high and out_stall_i is low.
// The front end smooths the samples and forms power, and a two-entry queue
// feeds the charge controller, so the front keeps taking items while a
// result waits on a stalled receiver; once the queue fills, in_stall_o rises.
// A tick that seeds the duty from the battery-to-source ratio runs the
// bit-serial divider, one quotient bit per cycle. The controller only
// takes the next item once the previous result has left. Configuration
// writes are taken in any cycle (cfg_ready_o is always high) and must
// only happen while the block is idle. Reset clears the averages, puts
// the charger in on mode with zero duty and loads the default
// thresholds; there is no clearing pass.
module solar_charge_tracker import sct_pkg::*; #(
  parameter int unsigned DUTY_FULL    = 1023,
  parameter int unsigned FLOAT_DUTY   = 0,
  parameter int unsigned SMOOTH_SHIFT = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       battery_mv_i,
  input  logic [15:0]       source_mv_i,
  input  logic [15:0]       source_ma_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [9:0]        duty_o,
  output logic              drive_enable_o,
  output logic [1:0]        mode_o,
  output logic [31:0]       source_power_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  sct_cfg_t           cfg_q;
  logic               push;
  sct_meas_t          push_data;
  logic               pop;
  sct_meas_t          pop_data;
  logic               fifo_empty;
  logic [FIFO_CW-1:0] fifo_count;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_battery_mv   <= RST_MIN_BATTERY_MV;
      cfg_q.high_battery_mv  <= RST_HIGH_BATTERY_MV;
      cfg_q.max_battery_mv   <= RST_MAX_BATTERY_MV;
      cfg_q.min_source_power <= RST_MIN_SOURCE_POWER;
      cfg_q.low_source_power <= RST_LOW_SOURCE_POWER;
      cfg_q.duty_step        <= RST_DUTY_STEP;
      cfg_q.start_duty       <= RST_START_DUTY;
      cfg_q.max_duty         <= RST_MAX_DUTY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_BATTERY_MV:   cfg_q.min_battery_mv   <= cfg_data_i[15:0];
        REG_HIGH_BATTERY_MV:  cfg_q.high_battery_mv  <= cfg_data_i[15:0];
        REG_MAX_BATTERY_MV:   cfg_q.max_battery_mv   <= cfg_data_i[15:0];
        REG_MIN_SOURCE_POWER: cfg_q.min_source_power <= cfg_data_i;
        REG_LOW_SOURCE_POWER: cfg_q.low_source_power <= cfg_data_i;
        REG_DUTY_STEP:        cfg_q.duty_step        <= cfg_data_i[9:0];
        REG_START_DUTY:       cfg_q.start_duty       <= cfg_data_i[9:0];
        REG_MAX_DUTY:         cfg_q.max_duty         <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  // Sample smoothing and power product.
  sct_front #(
    .SMOOTH_SHIFT(SMOOTH_SHIFT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .battery_mv_i (battery_mv_i),
    .source_mv_i  (source_mv_i),
    .source_ma_i  (source_ma_i),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Queue that lets the front run ahead of a busy or stalled controller.
  sct_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (fifo_empty),
    .count_o     (fifo_count)
  );

  // Mode machine, duty tracking and result register.
  sct_back #(
    .DUTY_FULL (DUTY_FULL),
    .FLOAT_DUTY(FLOAT_DUTY)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fifo_empty_i   (fifo_empty),
    .fifo_data_i    (pop_data),
    .fifo_pop_o     (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_o         (duty_o),
    .drive_enable_o (drive_enable_o),
    .mode_o         (mode_o),
    .source_power_o (source_power_o)
  );

  // The output stage runs in every mode but off.
  a_enable_tracks_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_enable_o == (mode_o != MODE_OFF)))
    else $error("drive enable disagrees with reported mode");

  // The reported duty never exceeds full scale.
  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (17'(duty_o) <= 17'(DUTY_FULL)))
    else $error("duty above full scale");

  // A full queue must hold off new items.
  a_queue_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_count == FIFO_CW'(FIFO_DEPTH)) |-> in_stall_o)
    else $error("front accepts while queue is full");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the perturb-and-observe solar charge tracker.
`timescale 1ns / 100ps

module tb;
  import sct_pkg::*;

  // The block's parameters and the values the predictor assumes for them.
  localparam int unsigned DUTY_FULL    = 1023;
  localparam int unsigned FLOAT_DUTY   = 0;
  localparam int unsigned SMOOTH_SHIFT = 3;

  // Quiet cycles after the last result before a register write or the end.
  // The divider path is the slowest, so this leaves margin.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // Register indexes past the end of the list. Writes to them must be dropped.
  localparam logic [CFG_IW-1:0] REG_SPARE_FIRST = REG_MAX_DUTY + 1'b1;
  localparam logic [CFG_IW-1:0] REG_SPARE_LAST  = '1;

  // One result item as the predictor expects it on the output ports.
  typedef struct packed {
    logic [9:0]  duty;
    logic        drive_en;
    logic [1:0]  mode;
    logic [31:0] power;
  } tick_result_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [15:0]       battery_mv_i   = '0;
  logic [15:0]       source_mv_i    = '0;
  logic [15:0]       source_ma_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [9:0]        duty_o;
  logic              drive_enable_o;
  logic [1:0]        mode_o;
  logic [31:0]       source_power_o;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i    = '0;
  logic [31:0]       cfg_data_i     = '0;

  solar_charge_tracker #(
    .DUTY_FULL    (DUTY_FULL),
    .FLOAT_DUTY   (FLOAT_DUTY),
    .SMOOTH_SHIFT (SMOOTH_SHIFT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .battery_mv_i   (battery_mv_i),
    .source_mv_i    (source_mv_i),
    .source_ma_i    (source_ma_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_o         (duty_o),
    .drive_enable_o (drive_enable_o),
    .mode_o         (mode_o),
    .source_power_o (source_power_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of everything the charger remembers, plus
  // the register file as this side believes it was last written.
  // ---------------------------------------------------------------------------
  sct_cfg_t     regs;
  logic [15:0]  bat_avg;
  logic [15:0]  srcv_avg;
  logic [15:0]  srci_avg;
  logic [1:0]   mode_now;
  int unsigned  duty_now;
  bit           step_down;
  logic [31:0]  last_power;

  // Results predicted for accepted items, oldest first.
  tick_result_t pending_results[$];

  int unsigned  errors     = 0;
  int unsigned  cycles     = 0;
  int unsigned  stall_left = 0;
  bit           idling     = 1'b0;
  bit           stalling   = 1'b0;

  initial begin
    regs.min_battery_mv   = RST_MIN_BATTERY_MV;
    regs.high_battery_mv  = RST_HIGH_BATTERY_MV;
    regs.max_battery_mv   = RST_MAX_BATTERY_MV;
    regs.min_source_power = RST_MIN_SOURCE_POWER;
    regs.low_source_power = RST_LOW_SOURCE_POWER;
    regs.duty_step        = RST_DUTY_STEP;
    regs.start_duty       = RST_START_DUTY;
    regs.max_duty         = RST_MAX_DUTY;
    bat_avg    = '0;
    srcv_avg   = '0;
    srci_avg   = '0;
    mode_now   = MODE_ON;
    duty_now   = 0;
    step_down  = 1'b0;
    last_power = '0;
  end

  // Moves an average toward the sample by one eighth of the gap (at the
  // default shift), truncating, so it settles within a few counts of it.
  function automatic logic [15:0] ease_toward(input logic [15:0] avg,
                                              input logic [15:0] sample);
    if (sample >= avg) return avg + ((sample - avg) >> SMOOTH_SHIFT);
    return avg - ((avg - sample) >> SMOOTH_SHIFT);
  endfunction

  function automatic int unsigned clamp_duty(input int unsigned d);
    return (d > DUTY_FULL) ? DUTY_FULL : d;
  endfunction

  // Advances the charger state by one tick and queues the result it reports.
  task automatic predict_tick(input logic [15:0] bat, input logic [15:0] src_v,
                              input logic [15:0] src_i);
    logic [31:0]  pwr;
    logic [63:0]  ratio;
    tick_result_t want;
    bat_avg  = ease_toward(bat_avg, bat);
    srcv_avg = ease_toward(srcv_avg, src_v);
    srci_avg = ease_toward(srci_avg, src_i);
    pwr = {16'd0, srcv_avg} * {16'd0, srci_avg};
    case (mode_now)
      MODE_OFF: begin
        // Float takes priority when the battery is already nearly full.
        if (bat_avg > regs.high_battery_mv && bat_avg < regs.max_battery_mv &&
            srcv_avg > bat_avg) begin
          duty_now = clamp_duty(FLOAT_DUTY);
          mode_now = MODE_FLOAT;
        end else if (bat_avg > regs.min_battery_mv &&
                     bat_avg < regs.max_battery_mv && srcv_avg > bat_avg) begin
          duty_now = clamp_duty(32'(regs.start_duty));
          mode_now = MODE_ON;
        end
      end
      MODE_ON: begin
        if (pwr < regs.min_source_power) begin
          mode_now = MODE_OFF;
        end else if (bat_avg > regs.max_battery_mv) begin
          duty_now = clamp_duty(FLOAT_DUTY);
          mode_now = MODE_FLOAT;
        end else if (pwr < regs.low_source_power) begin
          duty_now = clamp_duty(32'(regs.max_duty));
        end else begin
          // Seed the tracker at the battery-to-source voltage ratio.
          if (srcv_avg == 0) ratio = 64'(DUTY_FULL);
          else ratio = (64'(bat_avg) * 64'(DUTY_FULL)) / 64'(srcv_avg);
          duty_now  = (ratio > 64'(DUTY_FULL)) ? DUTY_FULL : 32'(ratio);
          step_down = 1'b0;
          mode_now  = MODE_BULK;
        end
      end
      MODE_BULK: begin
        if (pwr < regs.min_source_power) begin
          mode_now = MODE_OFF;
        end else if (bat_avg > regs.max_battery_mv) begin
          duty_now = clamp_duty(FLOAT_DUTY);
          mode_now = MODE_FLOAT;
        end else if (pwr < regs.low_source_power) begin
          duty_now = clamp_duty(32'(regs.start_duty));
          mode_now = MODE_ON;
        end else begin
          // Perturb and observe: reverse whenever power failed to rise.
          if (last_power >= pwr) step_down = !step_down;
          last_power = pwr;
          if (step_down)
            duty_now = (duty_now > 32'(regs.duty_step)) ?
                       duty_now - 32'(regs.duty_step) : 0;
          else
            duty_now = clamp_duty(duty_now + 32'(regs.duty_step));
        end
      end
      default: begin
        if (pwr < regs.min_source_power) begin
          mode_now = MODE_OFF;
        end else if (bat_avg > regs.max_battery_mv) begin
          if (duty_now > 0) duty_now = duty_now - 1;
        end else if (bat_avg < regs.max_battery_mv) begin
          // Running out of headroom hands control back to the tracker.
          if (duty_now + 1 >= DUTY_FULL) begin
            step_down = 1'b0;
            mode_now  = MODE_BULK;
          end else begin
            duty_now = duty_now + 1;
          end
        end
      end
    endcase
    want.duty     = duty_now[9:0];
    want.drive_en = (mode_now != MODE_OFF);
    want.mode     = mode_now;
    want.power    = pwr;
    pending_results.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------------
  // Idle lengths: mostly back to back, some short pauses, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Offers one sensor tick and predicts its result once the block takes it.
  // Valid is only dropped during a gap, so back-to-back items keep it high.
  task automatic send_tick(input logic [15:0] bat, input logic [15:0] src_v,
                           input logic [15:0] src_i);
    int unsigned gap;
    gap = idling ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    battery_mv_i <= bat;
    source_mv_i  <= src_v;
    source_ma_i  <= src_i;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tick(bat, src_v, src_i);
  endtask

  // Lets every outstanding result drain, then SETTLE_CYCLES quiet cycles more.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it into the predictor's register file.
  // Callers make sure the block is idle first.
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MIN_BATTERY_MV:   regs.min_battery_mv   = data[15:0];
      REG_HIGH_BATTERY_MV:  regs.high_battery_mv  = data[15:0];
      REG_MAX_BATTERY_MV:   regs.max_battery_mv   = data[15:0];
      REG_MIN_SOURCE_POWER: regs.min_source_power = data;
      REG_LOW_SOURCE_POWER: regs.low_source_power = data;
      REG_DUTY_STEP:        regs.duty_step        = data[9:0];
      REG_START_DUTY:       regs.start_duty       = data[9:0];
      REG_MAX_DUTY:         regs.max_duty         = data[9:0];
      default: ;
    endcase
  endtask

  // Loads a whole threshold set. Narrow registers get junk in their unused
  // upper data bits (16-bit ones from kind 2 on) so the write masking is exercised.
  task automatic load_settings(input int unsigned kind);
    sct_cfg_t s;
    logic [15:0] junk;
    junk = (kind >= 2) ? 16'($urandom) : 16'd0;
    case (kind)
      0: begin
        s = '{RST_MIN_BATTERY_MV, RST_HIGH_BATTERY_MV, RST_MAX_BATTERY_MV,
              RST_MIN_SOURCE_POWER, RST_LOW_SOURCE_POWER, RST_DUTY_STEP,
              RST_START_DUTY, RST_MAX_DUTY};
      end
      1: begin
        s.min_battery_mv   = 16'($urandom_range(9000, 12000));
        s.high_battery_mv  = s.min_battery_mv + 16'($urandom_range(0, 3000));
        s.max_battery_mv   = s.high_battery_mv + 16'($urandom_range(0, 2000));
        s.min_source_power = $urandom_range(0, 4000000);
        s.low_source_power = s.min_source_power + $urandom_range(0, 30000000);
        s.duty_step        = 10'($urandom_range(1, 40));
        s.start_duty       = 10'($urandom_range(0, 1023));
        s.max_duty         = 10'($urandom_range(0, 1023));
      end
      2: begin
        // Wide open: nothing stops tracking, and each step is the largest.
        s.min_battery_mv   = '0;
        s.high_battery_mv  = 16'($urandom_range(11000, 14000));
        s.max_battery_mv   = '1;
        s.min_source_power = '0;
        s.low_source_power = '0;
        s.duty_step        = 10'd1023;
        s.start_duty       = 10'd1023;
        s.max_duty         = 10'd0;
      end
      default: begin
        // Locked out: every mode collapses to off and off never restarts.
        s.min_battery_mv   = '1;
        s.high_battery_mv  = '1;
        s.max_battery_mv   = '0;
        s.min_source_power = '1;
        s.low_source_power = '1;
        s.duty_step        = 10'd1;
        s.start_duty       = 10'd0;
        s.max_duty         = 10'd1023;
      end
    endcase
    write_reg(REG_MIN_BATTERY_MV,   {junk, s.min_battery_mv});
    write_reg(REG_HIGH_BATTERY_MV,  {junk, s.high_battery_mv});
    write_reg(REG_MAX_BATTERY_MV,   {junk, s.max_battery_mv});
    write_reg(REG_MIN_SOURCE_POWER, s.min_source_power);
    write_reg(REG_LOW_SOURCE_POWER, s.low_source_power);
    write_reg(REG_DUTY_STEP,        {junk, 6'($urandom), s.duty_step});
    write_reg(REG_START_DUTY,       {junk, 6'($urandom), s.start_duty});
    write_reg(REG_MAX_DUTY,         {junk, 6'($urandom), s.max_duty});
  endtask

  function automatic logic [15:0] clip16(input int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic int jitter(input int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Panel currents: dark, dim and full sun, full sun being the common case.
  function automatic int pick_current();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 40);
      1:       return $urandom_range(40, 250);
      default: return $urandom_range(250, 9000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Straight out of reset the charger is in on mode with zero averages. With
  // both power thresholds at zero the first tick seeds the duty while the
  // source voltage is zero, which must saturate at full duty. The second tick
  // sees no power gain in bulk and must reverse the step.
  task automatic test_zero_source_seed();
    write_reg(REG_MIN_SOURCE_POWER, 32'd0);
    write_reg(REG_LOW_SOURCE_POWER, 32'd0);
    send_tick(16'd0, 16'd0, 16'd0);
    send_tick(16'd0, 16'd0, 16'd0);
    wait_idle();
  endtask

  // Extremes and alternating bit patterns of every field at default settings.
  task automatic test_field_extremes();
    write_reg(REG_MIN_SOURCE_POWER, RST_MIN_SOURCE_POWER);
    write_reg(REG_LOW_SOURCE_POWER, RST_LOW_SOURCE_POWER);
    send_tick(16'h0000, 16'h0000, 16'h0000);
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(16'hFFFF, 16'h0000, 16'hFFFF);
    send_tick(16'h0000, 16'hFFFF, 16'h0000);
    send_tick(16'hAAAA, 16'h5555, 16'hAAAA);
    send_tick(16'h5555, 16'hAAAA, 16'h5555);
    wait_idle();
  endtask

  // Walks the charger through every mode and transition by steering the
  // thresholds, using the predicted averages to pick the next tick.
  task automatic test_mode_walk();
    int unsigned n;
    // An unreachable power floor forces off from any mode.
    write_reg(REG_MIN_SOURCE_POWER, 32'hFFFF_FFFF);
    send_tick(16'd20000, 16'd20000, 16'd20000);
    wait_idle();

    // Off to on: float is out of reach, the battery window is the full range.
    write_reg(REG_MIN_SOURCE_POWER, 32'd0);
    write_reg(REG_LOW_SOURCE_POWER, 32'hFFFF_FFFF);
    write_reg(REG_MIN_BATTERY_MV,   32'd0);
    write_reg(REG_HIGH_BATTERY_MV,  32'd65535);
    write_reg(REG_MAX_BATTERY_MV,   32'd65535);
    n = 0;
    while (mode_now != MODE_ON && n < 8) begin
      send_tick(16'd0, 16'hFFFF, 16'd0);
      n++;
    end
    // A weak source holds on mode at max_duty; push the battery above the
    // source meanwhile so the next seed has a ratio above one.
    n = 0;
    do begin
      send_tick(16'hFFFF, 16'd0, 16'hFFFF);
      n++;
    end while (bat_avg <= srcv_avg && n < 10);
    wait_idle();
    write_reg(REG_LOW_SOURCE_POWER, 32'd0);
    send_tick(16'hFFFF, 16'd0, 16'hFFFF);
    send_tick(16'hFFFF, 16'd0, 16'hFFFF);
    wait_idle();

    // Bulk to float once the battery passes the ceiling; float at zero duty
    // cannot go lower.
    write_reg(REG_MAX_BATTERY_MV, 32'd0);
    send_tick(16'd30000, 16'd30000, 16'd1000);
    send_tick(16'd30000, 16'd30000, 16'd1000);
    wait_idle();
    write_reg(REG_MAX_BATTERY_MV, 32'd65535);
    send_tick(16'd30000, 16'd30000, 16'd1000);
    wait_idle();
    // Battery exactly at the ceiling: repeating the averages as samples keeps
    // them fixed, so float must hold its duty.
    write_reg(REG_MAX_BATTERY_MV, {16'd0, bat_avg});
    send_tick(bat_avg, srcv_avg, srci_avg);
    wait_idle();

    // Off straight to float when the battery is above the high mark.
    write_reg(REG_MIN_SOURCE_POWER, 32'hFFFF_FFFF);
    send_tick(16'd0, 16'hFFFF, 16'd100);
    wait_idle();
    write_reg(REG_MIN_SOURCE_POWER, 32'd0);
    write_reg(REG_HIGH_BATTERY_MV,  32'd0);
    write_reg(REG_MAX_BATTERY_MV,   32'd65535);
    send_tick(16'd0, 16'hFFFF, 16'd100);
    wait_idle();

    // Indexes past the register list must leave every threshold alone.
    write_reg(REG_SPARE_FIRST, $urandom);
    write_reg(REG_SPARE_LAST,  32'hFFFF_FFFF);
    send_tick(16'd12000, 16'd18000, 16'd3000);
    wait_idle();
  endtask

  // Float only raises the duty by one per tick, so reaching the top and the
  // hand-back to bulk takes about a thousand ticks with the battery below
  // the ceiling and the power floor out of the way.
  task automatic test_float_climb();
    int unsigned n;
    write_reg(REG_MIN_SOURCE_POWER, 32'hFFFF_FFFF);
    send_tick(16'd20000, 16'd60000, 16'd1000);
    wait_idle();
    write_reg(REG_MIN_SOURCE_POWER, 32'd0);
    write_reg(REG_LOW_SOURCE_POWER, 32'd0);
    write_reg(REG_MIN_BATTERY_MV,   32'd0);
    write_reg(REG_HIGH_BATTERY_MV,  32'd0);
    write_reg(REG_MAX_BATTERY_MV,   32'd65535);
    n = 0;
    while (mode_now != MODE_FLOAT && n < 60) begin
      send_tick(16'($urandom_range(1000, 40000)), 16'($urandom_range(50000, 65535)),
                16'($urandom));
      n++;
    end
    n = 0;
    while (mode_now == MODE_FLOAT && n < 1100) begin
      send_tick(16'($urandom_range(0, 40000)), 16'($urandom_range(40000, 65535)),
                16'($urandom));
      n++;
    end
    // A few ticks of tracking after the hand-back.
    repeat (10) send_tick(16'($urandom_range(0, 40000)), 16'($urandom), 16'($urandom));
    wait_idle();
  endtask

  // One operating condition held for a while: targets with small jitter,
  // an occasional change of sunlight and some fully random ticks mixed in.
  task automatic run_scenario(output int unsigned n);
    int bat_t;
    int src_t;
    int cur_t;
    int unsigned len;
    bat_t = $urandom_range(8000, 16500);
    src_t = bat_t + int'($urandom_range(0, 9000)) - 1500;
    cur_t = pick_current();
    len   = $urandom_range(15, 90);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(0, 24) == 0) cur_t = pick_current();
        send_tick(clip16(bat_t + jitter(150)), clip16(src_t + jitter(300)),
                  clip16(cur_t + jitter(200)));
      end
    end
    n = len;
  endtask

  // Random traffic in phases. The threshold set changes every five scenarios;
  // the first four sets go through each kind of set once.
  task automatic test_random_traffic(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    int unsigned kind;
    int unsigned r;
    sent  = 0;
    phase = 0;
    while (sent < target) begin
      if (phase % 5 == 0) begin
        wait_idle();
        if (phase < 20) begin
          kind = phase / 5;
        end else begin
          r = $urandom_range(0, 99);
          kind = (r < 20) ? 0 : (r < 75) ? 1 : (r < 90) ? 2 : 3;
        end
        load_settings(kind);
      end
      idling   = ($urandom_range(0, 3) != 0);
      stalling = ($urandom_range(0, 3) != 0);
      run_scenario(n);
      sent += n;
      phase++;
    end
    idling   = 1'b0;
    stalling = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order comparison.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stalling && $urandom_range(0, 99) < 20) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_stall_len() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: duty %0d mode %0d power %0d",
               duty_o, mode_o, source_power_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (duty_o !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, duty_o);
          errors++;
        end
        if (drive_enable_o !== want.drive_en) begin
          $error("drive_enable: expected %0d, got %0d", want.drive_en, drive_enable_o);
          errors++;
        end
        if (mode_o !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode_o);
          errors++;
        end
        if (source_power_o !== want.power) begin
          $error("source_power: expected %0d, got %0d", want.power, source_power_o);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed tests with idling on both sides, the long
  // float climb, then the bulk of random traffic.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling   = 1'b1;
    stalling = 1'b1;
    test_zero_source_seed();
    test_field_extremes();
    test_mode_walk();
    test_float_climb();
    test_random_traffic(900);
    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sct_pkg.sv
hdl/sct_front.sv
hdl/sct_fifo.sv
hdl/sct_div.sv
hdl/sct_back.sv
hdl/solar_charge_tracker.sv
tb/tb.sv
